### hw/rtl/mrse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrse_pkg: shared types and constants of the mask row span extractor
// Frame geometry limits, record kinds and the command word passed from
// the front end to the back end.
// ----------------------------------------------------------------------------
package mrse_pkg;

	// geometry
	localparam int MAX_DIM   = 4096;
	localparam int COORD_W   = $clog2(MAX_DIM);
	localparam int LEN_W     = COORD_W + 1;
	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_RESET = 256;

	// command queue depth
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	// record kinds, also used as bit positions of the kind mask
	typedef enum logic [1:0] {
		REC_SPAN  = 2'd0,
		REC_ROW   = 2'd1,
		REC_FRAME = 2'd2
	} rec_kind_t;

	localparam int NUM_KINDS = 3;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_WIDTH  = 1'b0,
		CFG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	// one command word: every record caused by one input word
	typedef struct packed {
		logic [NUM_KINDS-1:0] kinds;
		logic [COORD_W-1:0]   row;
		logic [COORD_W-1:0]   span_start;
		logic [LEN_W-1:0]     span_end;
		logic [LEN_W-1:0]     span_len;
		logic [LEN_W-1:0]     row_longest;
		logic [COORD_W-1:0]   best_row;
		logic [COORD_W-1:0]   best_col;
		logic [LEN_W-1:0]     best_len;
	} mrse_cmd_t;

	// queue status toward the front and back ends
	typedef struct packed {
		logic empty;
		logic full;
	} mrse_fifo_st_t;

	// clamp a dimension to 1..MAX_DIM and return its last index
	function automatic logic [COORD_W-1:0] last_index(input logic [CFG_W-1:0] v);
		int d;
		d = int'(v);
		if (d < 1) begin
			d = 1;
		end else if (d > MAX_DIM) begin
			d = MAX_DIM;
		end
		return COORD_W'(d - 1);
	endfunction

endpackage

### hw/rtl/mask_row_span_extractor_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mask_row_span_extractor_core: run-length span extraction from a mask
// Front end, command queue and record back end of the span extractor.
// ----------------------------------------------------------------------------
// Usage:
//   Input: one mask bit per word in raster order, taken at an edge with
//   push high and full low. Column and row are counted internally from the
//   frame_width / frame_height registers (cfg index 0 and 1, 0 counts as 1,
//   values above 4096 count as 4096).
//   Output: records (span, row summary, frame summary) while empty is low,
//   taken with pop. last_of_run marks the final record of one input word.
//   Order: the command of a pixel is written into the command queue, and its
//   first record then into the output register. Throughput: one pixel per
//   cycle while records drain one per cycle; the 4-entry command queue
//   absorbs row-end bursts, and with very narrow rows full throttles input.
//   A stalled receiver fills the queue and then raises full.
//   Reset clears the scan position, the run, the maxima, the queue and the
//   output valid flag; width and height return to 256. Configuration must
//   be written only while no word is in flight; the block does not check.
// ----------------------------------------------------------------------------
module mask_row_span_extractor_core import mrse_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 push,
	output logic                 full,
	input  logic                 mask_bit,
	input  logic                 pop,
	output logic                 empty,
	output logic [1:0]           record_kind,
	output logic [COORD_W-1:0]   row_index,
	output logic [COORD_W-1:0]   span_start,
	output logic [LEN_W-1:0]     span_end,
	output logic [LEN_W-1:0]     span_length,
	output logic                 last_of_run
);

	logic          accept, cmd_push, fifo_pop;
	mrse_cmd_t     cmd_in, cmd_head;
	mrse_fifo_st_t fifo_st;

	// input handshake
	assign full   = fifo_st.full;
	assign accept = push && !fifo_st.full;

	mrse_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.mask_bit  (mask_bit),
		.cmd_push  (cmd_push),
		.cmd       (cmd_in)
	);

	mrse_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cmd_push),
		.wr_cmd (cmd_in),
		.rd_en  (fifo_pop),
		.rd_cmd (cmd_head),
		.st     (fifo_st)
	);

	mrse_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (cmd_head),
		.fifo_st     (fifo_st),
		.fifo_pop    (fifo_pop),
		.pop         (pop),
		.empty       (empty),
		.record_kind (record_kind),
		.row_index   (row_index),
		.span_start  (span_start),
		.span_end    (span_end),
		.span_length (span_length),
		.last_of_run (last_of_run)
	);

`ifndef SYNTHESIS
	// queue can never be both empty and full
	a_fifo_state: assert property (@(posedge clk) disable iff (!arst_n)
		!(fifo_st.empty && fifo_st.full))
		else $error("command queue empty and full at once");

	// every queued command carries at least one record
	a_cmd_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> (cmd_in.kinds != '0))
		else $error("empty command pushed");

	// a frame summary always comes with its row summary
	a_frame_has_row: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_push && cmd_in.kinds[REC_FRAME]) |-> cmd_in.kinds[REC_ROW])
		else $error("frame summary without row summary");

	// a pending command reaches a free output register in the next cycle
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(!fifo_st.empty && empty) |=> !empty)
		else $error("back end failed to present a pending record");
`endif

endmodule

### hw/rtl/mrse_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrse_front: pixel front end
// Counts columns and rows, tracks the open run and the row and frame
// maxima, and turns each accepted word that closes a span or ends a row
// into one command for the back end.
module mrse_front import mrse_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 accept,
	input  logic                 mask_bit,
	output logic                 cmd_push,
	output mrse_cmd_t            cmd
);

	logic [COORD_W-1:0] wlast_q, hlast_q;
	logic [COORD_W-1:0] col_q, row_q, run_start_q;
	logic               run_open_q;
	logic [LEN_W-1:0]   row_longest_q, best_len_q;
	logic [COORD_W-1:0] best_col_q, best_row_q;

	logic               close_clear, open_now, row_end, frame_end;
	logic               run_open_mid, has_span;
	logic [COORD_W-1:0] start_mid;
	logic [LEN_W-1:0]   span_end, span_len, row_longest_nx, best_len_nx;
	logic [COORD_W-1:0] best_col_nx, best_row_nx;

	// classify the word against the run and the frame geometry
	always_comb begin
		close_clear  = run_open_q && !mask_bit;
		open_now     = !run_open_q && mask_bit;
		row_end      = col_q >= wlast_q;
		frame_end    = row_end && (row_q >= hlast_q);
		run_open_mid = open_now ? 1'b1 : (close_clear ? 1'b0 : run_open_q);
		start_mid    = open_now ? col_q : run_start_q;
		has_span     = close_clear || (row_end && run_open_mid);
		// a clear bit ends the span at this column, a row end just after it
		span_end     = close_clear ? LEN_W'(col_q) : LEN_W'(col_q) + LEN_W'(1);
		span_len     = span_end - LEN_W'(start_mid);
	end

	// running maxima including the span closed by this word
	always_comb begin
		row_longest_nx = row_longest_q;
		best_len_nx    = best_len_q;
		best_col_nx    = best_col_q;
		best_row_nx    = best_row_q;
		if (has_span && (span_len > row_longest_q)) begin
			row_longest_nx = span_len;
		end
		if (has_span && (span_len > best_len_q)) begin
			best_len_nx = span_len;
			best_col_nx = start_mid;
			best_row_nx = row_q;
		end
	end

	// command word toward the queue
	always_comb begin
		cmd.kinds              = '0;
		cmd.kinds[REC_SPAN]    = has_span;
		cmd.kinds[REC_ROW]     = row_end;
		cmd.kinds[REC_FRAME]   = frame_end;
		cmd.row                = row_q;
		cmd.span_start         = start_mid;
		cmd.span_end           = span_end;
		cmd.span_len           = span_len;
		cmd.row_longest        = row_longest_nx;
		cmd.best_row           = best_row_nx;
		cmd.best_col           = best_col_nx;
		cmd.best_len           = best_len_nx;
		cmd_push               = accept && (has_span || row_end);
	end

	// geometry registers, stored as clamped last indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlast_q <= last_index(CFG_W'(CFG_RESET));
			hlast_q <= last_index(CFG_W'(CFG_RESET));
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_FRAME_WIDTH:  wlast_q <= last_index(cfg_data);
				CFG_FRAME_HEIGHT: hlast_q <= last_index(cfg_data);
				default: ;
			endcase
		end
	end

	// scan position, run and maxima
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q         <= '0;
			row_q         <= '0;
			run_open_q    <= 1'b0;
			run_start_q   <= '0;
			row_longest_q <= '0;
			best_len_q    <= '0;
			best_col_q    <= '0;
			best_row_q    <= '0;
		end else if (accept) begin
			run_start_q <= start_mid;
			if (row_end) begin
				col_q         <= '0;
				run_open_q    <= 1'b0;
				row_longest_q <= '0;
				row_q         <= frame_end ? '0 : row_q + COORD_W'(1);
			end else begin
				col_q         <= col_q + COORD_W'(1);
				run_open_q    <= run_open_mid;
				row_longest_q <= row_longest_nx;
			end
			if (frame_end) begin
				best_len_q <= '0;
				best_col_q <= '0;
				best_row_q <= '0;
			end else begin
				best_len_q <= best_len_nx;
				best_col_q <= best_col_nx;
				best_row_q <= best_row_nx;
			end
		end
	end

endmodule

### hw/rtl/mrse_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrse_cmd_fifo: command queue
// Small register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module mrse_cmd_fifo import mrse_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  mrse_cmd_t     wr_cmd,
	input  logic          rd_en,
	output mrse_cmd_t     rd_cmd,
	output mrse_fifo_st_t st
);

	mrse_cmd_t          mem_q [FIFO_DEPTH];
	logic [FIFO_AW:0]   wptr_q, rptr_q;
	logic [FIFO_AW:0]   fill;

	// occupancy from the wrap-extended pointers
	always_comb begin
		fill     = wptr_q - rptr_q;
		st.empty = (fill == '0);
		st.full  = (fill == (FIFO_AW+1)'(FIFO_DEPTH));
		rd_cmd   = mem_q[rptr_q[FIFO_AW-1:0]];
	end

	// storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wptr_q[FIFO_AW-1:0]] <= wr_cmd;
		end
	end

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
		end else begin
			if (wr_en) begin
				wptr_q <= wptr_q + (FIFO_AW+1)'(1);
			end
			if (rd_en) begin
				rptr_q <= rptr_q + (FIFO_AW+1)'(1);
			end
		end
	end

endmodule

### hw/rtl/mrse_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrse_back: record back end
// Expands the head command into its span, row and frame records in the
// output register, one per cycle unless the receiver stalls on pop.
// ----------------------------------------------------------------------------
module mrse_back import mrse_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  mrse_cmd_t          head,
	input  mrse_fifo_st_t      fifo_st,
	output logic               fifo_pop,
	input  logic               pop,
	output logic               empty,
	output logic [1:0]         record_kind,
	output logic [COORD_W-1:0] row_index,
	output logic [COORD_W-1:0] span_start,
	output logic [LEN_W-1:0]   span_end,
	output logic [LEN_W-1:0]   span_length,
	output logic               last_of_run
);

	logic [NUM_KINDS-1:0] done_q, avail, sel, remain;
	logic                 out_valid_q, load, is_last;
	rec_kind_t            kind_nx;
	logic [COORD_W-1:0]   row_nx, start_nx;
	logic [LEN_W-1:0]     end_nx, len_nx;

	// pick the first pending record of the head command: span, then row, then frame
	always_comb begin
		avail    = head.kinds & ~done_q;
		sel      = '0;
		kind_nx  = REC_FRAME;
		row_nx   = head.best_row;
		start_nx = head.best_col;
		end_nx   = '0;
		len_nx   = head.best_len;
		priority if (avail[REC_SPAN]) begin
			sel[REC_SPAN] = 1'b1;
			kind_nx       = REC_SPAN;
			row_nx        = head.row;
			start_nx      = head.span_start;
			end_nx        = head.span_end;
			len_nx        = head.span_len;
		end else if (avail[REC_ROW]) begin
			sel[REC_ROW] = 1'b1;
			kind_nx      = REC_ROW;
			row_nx       = head.row;
			start_nx     = '0;
			len_nx       = head.row_longest;
		end else begin
			sel[REC_FRAME] = 1'b1;
		end
		remain   = avail & ~sel;
		is_last  = (remain == '0);
		load     = !fifo_st.empty && (!out_valid_q || pop);
		fifo_pop = load && is_last;
		empty    = !out_valid_q;
	end

	// progress through the head command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				done_q      <= is_last ? '0 : (done_q | sel);
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (load) begin
			record_kind <= kind_nx;
			row_index   <= row_nx;
			span_start  <= start_nx;
			span_end    <= end_nx;
			span_length <= len_nx;
			last_of_run <= is_last;
		end
	end

endmodule
